// ----- rtl/rc_pwm_pulse_capture_assert.svh -----
// Assertion helpers; clk and rst are taken from the module that uses them.
`ifndef RC_PWM_PULSE_CAPTURE_ASSERT_SVH
`define RC_PWM_PULSE_CAPTURE_ASSERT_SVH

// Same-cycle implication.
`define RCPC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc_pwm_pulse_capture: assertion failed");

// Next-cycle implication.
`define RCPC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc_pwm_pulse_capture: assertion failed");

`endif

// ----- rtl/rcpc_pkg.sv -----
`default_nettype none

package rcpc_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int MASK_W       = 4;
  // the channel-count register is 3 bits, so a required mask spans at most 7 channels
  localparam int NEED_W       = 8;

  localparam logic [15:0] MIN_SLACK = 16'd200;
  localparam logic [16:0] MAX_SLACK = 17'd500;
  localparam logic [31:0] AGE_NEVER = 32'hFFFF_FFFF;

  localparam logic [2:0]  NUM_CHANNELS_RST = 3'd4;
  localparam logic [15:0] MIN_PULSE_RST    = 16'd1000;
  localparam logic [15:0] MAX_PULSE_RST    = 16'd2000;
  localparam logic [31:0] TIMEOUT_RST      = 32'd100000;
  localparam logic [15:0] TIMER_RELOAD_RST = 16'd65535;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_NUM_CHANNELS = 3'd0,
    REG_MIN_PULSE    = 3'd1,
    REG_MAX_PULSE    = 3'd2,
    REG_TIMEOUT      = 3'd3,
    REG_TIMER_RELOAD = 3'd4
  } reg_idx_t;

  // per-channel state word held in the channel memory
  typedef struct packed {
    logic        expect_fall;
    logic [15:0] rise_stamp;
    logic [16:0] stored_width;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/rcpc_chan_mem.sv -----
`default_nettype none

module rcpc_chan_mem #(
  parameter int DEPTH = rcpc_pkg::CHANNELS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire rcpc_pkg::entry_t wr_data,
  output rcpc_pkg::entry_t     rd_data
);

  rcpc_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // write-first: a read that meets a write to the same entry takes the new word;
  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else if (vld[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rc_pwm_pulse_capture.sv -----
// RC PWM pulse capture.
// Input channel (in_valid / in_stall): opcode selects an edge item (channel,
// capture_time, now_us) or a status poll (now_us). Output channel (out_valid /
// out_stall) returns exactly one result item per input item, in order.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes registers
// 0..4; cfg_ready is always high. Write config only while the block is idle.
// Path: an accepted item passes the channel memory read, then a read-modify-write
// into the output register, where its result can be taken.
// Throughput: one item per cycle unless out_stall holds a result; a channel word
// read in the same cycle as a write to it is forwarded inside the memory.
// Reset: every channel expects a rising edge, all counters and status clear,
// registers take their default values, no result is pending.
// Stall: a stalled result holds in the output register; the item behind it
// waits in the compute stage and in_stall goes high until out_stall drops.
`default_nettype none
`include "rc_pwm_pulse_capture_assert.svh"

module rc_pwm_pulse_capture #(
  parameter int CHANNELS = rcpc_pkg::CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [1:0]  channel,
  input  wire logic [15:0] capture_time,
  input  wire logic [31:0] now_us,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      pulse_width,
  output logic             width_stored,
  output logic             next_edge_falling,
  output logic             frame_published,
  output logic [31:0]      frame_count,
  output logic [3:0]       published_mask,
  output logic [31:0]      frame_age,
  output logic             link_healthy,
  output logic             sample_valid,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MASK_W = rcpc_pkg::MASK_W;
  localparam int NEED_W = rcpc_pkg::NEED_W;

  // configuration registers
  logic [2:0]  chan_count;
  logic [15:0] pulse_min;
  logic [15:0] pulse_max;
  logic [31:0] link_timeout;
  logic [15:0] timer_reload;

  // compute stage
  logic        s1_valid;
  logic        s1_op;
  logic [1:0]  s1_ch;
  logic [15:0] s1_t;
  logic [31:0] s1_now;

  // global state
  logic [MASK_W-1:0] gather_mask;
  logic [31:0]       frames_done;
  logic [31:0]       last_frame_time;
  logic [MASK_W-1:0] frame_mask;
  logic [31:0]       status_age;
  logic              status_link;
  logic [MASK_W-1:0] status_mask;

  logic accept_in;
  logic commit;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  rcpc_pkg::entry_t ent;
  rcpc_pkg::entry_t ent_next;

  logic              ch_ok;
  logic [2:0]        num_eff;
  logic [NEED_W-1:0] need;
  logic [15:0]       lo;
  logic [16:0]       hi;
  logic [16:0]       width;
  logic              stored;
  logic              published;
  logic              nfall;
  logic [MASK_W-1:0] bit_m;
  logic [MASK_W-1:0] gather_mask_next;
  logic [31:0]       frames_done_next;
  logic [31:0]       last_frame_time_next;
  logic [MASK_W-1:0] frame_mask_next;
  logic [31:0]       status_age_next;
  logic              status_link_next;
  logic [MASK_W-1:0] status_mask_next;
  logic [31:0]       age;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count   <= rcpc_pkg::NUM_CHANNELS_RST;
      pulse_min    <= rcpc_pkg::MIN_PULSE_RST;
      pulse_max    <= rcpc_pkg::MAX_PULSE_RST;
      link_timeout <= rcpc_pkg::TIMEOUT_RST;
      timer_reload <= rcpc_pkg::TIMER_RELOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rcpc_pkg::reg_idx_t'(cfg_index))
        rcpc_pkg::REG_NUM_CHANNELS: chan_count   <= cfg_data[2:0];
        rcpc_pkg::REG_MIN_PULSE:    pulse_min    <= cfg_data[15:0];
        rcpc_pkg::REG_MAX_PULSE:    pulse_max    <= cfg_data[15:0];
        rcpc_pkg::REG_TIMEOUT:      link_timeout <= cfg_data;
        rcpc_pkg::REG_TIMER_RELOAD: timer_reload <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign commit    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !commit;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_op  <= opcode;
      s1_ch  <= channel;
      s1_t   <= capture_time;
      s1_now <= now_us;
    end
  end

  assign rd_addr = AW'(channel);
  assign wr_addr = AW'(s1_ch);
  assign ch_ok   = 32'(s1_ch) < 32'(CHANNELS);
  assign wr_en   = commit && (s1_op == rcpc_pkg::OP_EDGE) && ch_ok;

  rcpc_chan_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept_in),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ent_next),
    .rd_data (ent)
  );

  // limits derived from the config
  assign num_eff = (32'(chan_count) > 32'(CHANNELS)) ? 3'(CHANNELS) : chan_count;
  assign need    = NEED_W'((9'd1 << num_eff) - 9'd1);
  assign lo      = (pulse_min >= rcpc_pkg::MIN_SLACK) ?
                   (pulse_min - rcpc_pkg::MIN_SLACK) : 16'd0;
  assign hi      = {1'b0, pulse_max} + rcpc_pkg::MAX_SLACK;
  assign bit_m   = MASK_W'(1) << s1_ch;

  always_comb begin
    ent_next             = ent;
    width                = 17'd0;
    stored               = 1'b0;
    published            = 1'b0;
    nfall                = 1'b0;
    gather_mask_next     = gather_mask;
    frames_done_next     = frames_done;
    last_frame_time_next = last_frame_time;
    frame_mask_next      = frame_mask;
    status_age_next      = status_age;
    status_link_next     = status_link;
    status_mask_next     = status_mask;
    age = (last_frame_time == 32'd0) ? rcpc_pkg::AGE_NEVER : (s1_now - last_frame_time);

    if (s1_op == rcpc_pkg::OP_POLL) begin
      status_age_next  = age;
      status_mask_next = frame_mask;
      status_link_next = (last_frame_time != 32'd0) && (age <= link_timeout);
    end else if (ch_ok) begin
      if (!ent.expect_fall) begin
        ent_next.expect_fall = 1'b1;
        ent_next.rise_stamp  = s1_t;
      end else begin
        ent_next.expect_fall = 1'b0;
        // wrap at the timer reload, modulo 2^17
        if (s1_t >= ent.rise_stamp) begin
          width = {1'b0, s1_t} - {1'b0, ent.rise_stamp};
        end else begin
          width = {1'b0, timer_reload} + 17'd1 - {1'b0, ent.rise_stamp} + {1'b0, s1_t};
        end
        if (width < {1'b0, lo}) begin
          // too short: ignored
        end else if (width > hi) begin
          gather_mask_next = gather_mask & ~bit_m;
        end else begin
          ent_next.stored_width = width;
          stored = 1'b1;
          if (width >= {1'b0, pulse_min} && width <= {1'b0, pulse_max}) begin
            gather_mask_next = gather_mask | bit_m;
            if ((NEED_W'(gather_mask_next) & need) == need) begin
              frames_done_next     = frames_done + 32'd1;
              last_frame_time_next = s1_now;
              frame_mask_next      = gather_mask_next;
              gather_mask_next     = '0;
              published            = 1'b1;
            end
          end else begin
            gather_mask_next = gather_mask & ~bit_m;
          end
        end
      end
      nfall = ent_next.expect_fall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gather_mask     <= '0;
      frames_done     <= '0;
      last_frame_time <= '0;
      frame_mask      <= '0;
      status_age      <= '0;
      status_link     <= 1'b0;
      status_mask     <= '0;
    end else if (commit) begin
      gather_mask     <= gather_mask_next;
      frames_done     <= frames_done_next;
      last_frame_time <= last_frame_time_next;
      frame_mask      <= frame_mask_next;
      status_age      <= status_age_next;
      status_link     <= status_link_next;
      status_mask     <= status_mask_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pulse_width       <= width;
      width_stored      <= stored;
      next_edge_falling <= nfall;
      frame_published   <= published;
      frame_count       <= frames_done_next;
      published_mask    <= frame_mask_next;
      frame_age         <= status_age_next;
      link_healthy      <= status_link_next;
      sample_valid      <= ((NEED_W'(status_mask_next) & need) == need) && status_link_next;
    end
  end

  `RCPC_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid)
  `RCPC_ASSERT_NXT(a_publish_counts, commit && published,
                   frames_done == $past(frames_done) + 32'd1)
  `RCPC_ASSERT_NXT(a_publish_clears_gather, commit && published, gather_mask == '0)
  `RCPC_ASSERT_NOW(a_publish_implies_stored, out_valid && frame_published, width_stored)
  `RCPC_ASSERT_NOW(a_stored_ends_pulse, out_valid && width_stored, !next_edge_falling)

endmodule

`default_nettype wire
